// ===== rtl/tov_pkg.sv =====
// ----------------------------------------------------------------------------
// tov_pkg: shared types and constants of the top-off valve controller
// Item kinds, register map, register reset values and default sizes.
// ----------------------------------------------------------------------------
package tov_pkg;

  // Default sizes
  localparam int unsigned AlarmWindowDefault     = 8;
  localparam int unsigned SamplesPerCheckDefault = 8;

  // Field widths
  localparam int unsigned FuncW      = 2;
  localparam int unsigned SampleW    = 12;
  localparam int unsigned ThresholdW = 12;
  localparam int unsigned DelayW     = 32;
  localparam int unsigned SumW       = 16;

  // Configuration port
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  // Register reset values
  localparam logic [ThresholdW-1:0] ThresholdReset = 12'd2048;
  localparam logic [DelayW-1:0]     DelayReset     = 32'd5000;

  // Item kinds; the fourth code changes nothing
  typedef enum logic [FuncW-1:0] {
    FuncTick  = 2'd0,
    FuncAlarm = 2'd1,
    FuncLevel = 2'd2
  } func_e;

  // Register indexes, taken from paddr[2]
  typedef enum logic {
    RegOptoThreshold = 1'b0,
    RegValveDelay    = 1'b1
  } reg_e;

  // Register contents handed to the controller
  typedef struct packed {
    logic [ThresholdW-1:0] opto_threshold;
    logic [DelayW-1:0]     valve_delay;
  } cfg_t;

endpackage

// ===== rtl/tov_if.sv =====
// ----------------------------------------------------------------------------
// tov_in_if / tov_out_if: item and result channels
// Valid/ready channels carrying one request or one result.
// ----------------------------------------------------------------------------
interface tov_in_if;
  logic                         valid;
  logic                         ready;
  logic [tov_pkg::FuncW-1:0]    func;
  logic                         alarm_bit;
  logic [tov_pkg::SampleW-1:0]  level_sample;

  modport source (output valid, func, alarm_bit, level_sample, input ready);
  modport sink   (input valid, func, alarm_bit, level_sample, output ready);
endinterface

interface tov_out_if;
  logic valid;
  logic ready;
  logic valve_open;
  logic alarm_active;
  logic level_full;
  logic valve_changed;

  modport source (output valid, valve_open, alarm_active, level_full, valve_changed,
                  input ready);
  modport sink   (input valid, valve_open, alarm_active, level_full, valve_changed,
                  output ready);
endinterface

// ===== rtl/tov_cfg.sv =====
// ----------------------------------------------------------------------------
// tov_cfg: configuration registers
// APB-style register file holding the level threshold and the valve delay.
// ----------------------------------------------------------------------------
module tov_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tov_pkg::PaddrW-1:0]   paddr,
  input  logic [tov_pkg::PdataW-1:0]   pwdata,
  output logic [tov_pkg::PdataW-1:0]   prdata,
  output logic                         pready,
  output tov_pkg::cfg_t                cfg_o
);

  logic                              wr_en;
  tov_pkg::reg_e                     reg_sel;
  logic [tov_pkg::ThresholdW-1:0]    threshold_q;
  logic [tov_pkg::DelayW-1:0]        delay_q;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = tov_pkg::reg_e'(paddr[2]);

  // Write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= tov_pkg::ThresholdReset;
      delay_q     <= tov_pkg::DelayReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        tov_pkg::RegOptoThreshold: threshold_q <= pwdata[tov_pkg::ThresholdW-1:0];
        tov_pkg::RegValveDelay:    delay_q     <= pwdata[tov_pkg::DelayW-1:0];
        default:                   delay_q     <= delay_q;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (reg_sel)
      tov_pkg::RegOptoThreshold:
        prdata = {{(tov_pkg::PdataW-tov_pkg::ThresholdW){1'b0}}, threshold_q};
      tov_pkg::RegValveDelay:    prdata = delay_q;
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o.opto_threshold = threshold_q;
  assign cfg_o.valve_delay    = delay_q;

endmodule

// ===== rtl/tov_ctrl.sv =====
// ----------------------------------------------------------------------------
// tov_ctrl: valve control datapath
// Input register, controller state, one pass of update logic, result register.
// ----------------------------------------------------------------------------
module tov_ctrl #(
  parameter int unsigned AlarmWindow     = tov_pkg::AlarmWindowDefault,
  parameter int unsigned SamplesPerCheck = tov_pkg::SamplesPerCheckDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tov_pkg::cfg_t cfg_i,
  tov_in_if.sink        in_i,
  tov_out_if.source     out_o
);

  localparam int unsigned CntW = $clog2(SamplesPerCheck + 1);
  localparam int unsigned LimW = tov_pkg::SumW + 1;
  localparam logic [CntW-1:0] CntLast = CntW'(SamplesPerCheck);
  localparam logic [LimW-1:0] LimScale = LimW'(SamplesPerCheck);

  // Input register
  logic                           s1_valid_q;
  logic [tov_pkg::FuncW-1:0]      s1_func_q;
  logic                           s1_abit_q;
  logic [tov_pkg::SampleW-1:0]    s1_samp_q;
  logic                           advance;

  // Controller state
  logic [tov_pkg::DelayW-1:0]     elapsed_q, elapsed_d;
  logic                           valve_q, valve_d;
  logic [AlarmWindow-1:0]         win_q, win_d;
  logic                           alarm_q, alarm_d;
  logic [tov_pkg::SumW-1:0]       sum_q, sum_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic                           full_q, full_d;
  logic                           changed;

  // Result register
  logic                           r_valid_q;
  logic                           r_valve_q, r_alarm_q, r_full_q, r_changed_q;

  // Update terms
  logic                           hold_done;
  logic [AlarmWindow:0]           win_shift;
  logic [tov_pkg::SumW-1:0]       sum_add;
  logic [CntW-1:0]                cnt_inc;
  logic [LimW-1:0]                full_lim;
  logic                           level_over;

  // Move an item on when the result register is free or being drained
  assign advance    = s1_valid_q && (!r_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  // Capture the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_func_q <= in_i.func;
      s1_abit_q <= in_i.alarm_bit;
      s1_samp_q <= in_i.level_sample;
    end
  end

  // Valve may move only once the hold time is strictly exceeded
  assign hold_done = elapsed_q > cfg_i.valve_delay;
  assign win_shift = {win_q, s1_abit_q};
  assign sum_add   = sum_q + tov_pkg::SumW'(s1_samp_q);
  assign cnt_inc   = cnt_q + CntW'(1);
  // average above threshold  <=>  sum >= (threshold + 1) * samples
  assign full_lim  = (LimW'(cfg_i.opto_threshold) + LimW'(1)) * LimScale;
  assign level_over = {1'b0, sum_add} >= full_lim;

  // One update pass per item
  always_comb begin
    elapsed_d = elapsed_q;
    valve_d   = valve_q;
    win_d     = win_q;
    alarm_d   = alarm_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    full_d    = full_q;
    changed   = 1'b0;
    unique case (tov_pkg::func_e'(s1_func_q))
      tov_pkg::FuncTick: begin
        if (elapsed_q != '1) begin
          elapsed_d = elapsed_q + tov_pkg::DelayW'(1);
        end
      end
      tov_pkg::FuncAlarm: begin
        win_d   = win_shift[AlarmWindow-1:0];
        alarm_d = &win_shift[AlarmWindow-1:0];
        if (alarm_d && valve_q && hold_done) begin
          valve_d   = 1'b0;
          elapsed_d = '0;
          changed   = 1'b1;
        end
      end
      tov_pkg::FuncLevel: begin
        if (valve_q) begin
          if (cnt_inc == CntLast) begin
            full_d = level_over;
            sum_d  = '0;
            cnt_d  = '0;
            if (level_over && hold_done) begin
              valve_d   = 1'b0;
              elapsed_d = '0;
              changed   = 1'b1;
            end
          end else begin
            sum_d = sum_add;
            cnt_d = cnt_inc;
          end
        end else if (hold_done) begin
          // Sample ignored while closed; try to open
          valve_d   = 1'b1;
          elapsed_d = '0;
          changed   = 1'b1;
        end
      end
      default: begin
        changed = 1'b0;
      end
    endcase
  end

  // Commit state as the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      valve_q   <= 1'b0;
      win_q     <= '0;
      alarm_q   <= 1'b0;
      sum_q     <= '0;
      cnt_q     <= '0;
      full_q    <= 1'b0;
    end else if (advance) begin
      elapsed_q <= elapsed_d;
      valve_q   <= valve_d;
      win_q     <= win_d;
      alarm_q   <= alarm_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      full_q    <= full_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (advance) begin
      r_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      r_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      r_valve_q   <= valve_d;
      r_alarm_q   <= alarm_d;
      r_full_q    <= full_d;
      r_changed_q <= changed;
    end
  end

  assign out_o.valid         = r_valid_q;
  assign out_o.valve_open    = r_valve_q;
  assign out_o.alarm_active  = r_alarm_q;
  assign out_o.level_full    = r_full_q;
  assign out_o.valve_changed = r_changed_q;

endmodule

// ===== rtl/top_off_valve_controller.sv =====
// ----------------------------------------------------------------------------
// top_off_valve_controller: tank top-off fill valve controller
// Debounces the alarm float switch, averages optical level samples and drives
// the fill valve with a minimum hold time between changes.
// ----------------------------------------------------------------------------
// Path: an accepted item is captured in the input register, then moves to the
//   result register, where it is held until taken.
// Throughput: one item per cycle while results are taken; the update pass between
//   the input register and the result register holds no iteration.
// Reset: controller state clears, the valve is closed, registers return to
//   threshold 2048 and delay 5000 ticks; items are taken right after reset.
module top_off_valve_controller #(
  parameter int unsigned AlarmWindow     = tov_pkg::AlarmWindowDefault,
  parameter int unsigned SamplesPerCheck = tov_pkg::SamplesPerCheckDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tov_pkg::PaddrW-1:0]  paddr,
  input  logic [tov_pkg::PdataW-1:0]  pwdata,
  output logic [tov_pkg::PdataW-1:0]  prdata,
  output logic                        pready,
  tov_in_if.sink                      in_i,
  tov_out_if.source                   out_o
);

  tov_pkg::cfg_t cfg;

  // Register file
  tov_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Valve control datapath
  tov_ctrl #(
    .AlarmWindow     (AlarmWindow),
    .SamplesPerCheck (SamplesPerCheck)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
